// File: rtl/mfsv_pkg.sv
`timescale 1ns / 1ps

package mfsv_pkg;

    // Byte position counter width; the counter saturates at its all-ones value.
    localparam int POS_BITS = 26;
    // Bit width of the widest body end position of a header that passes the counts check.
    localparam int NEED_BITS = 22;
    localparam int LEN_BITS = (NEED_BITS > POS_BITS) ? NEED_BITS : POS_BITS;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam int HDR_LEN = 20;
    localparam logic [POS_BITS-1:0] HDR_BYTES = POS_BITS'(HDR_LEN);
    localparam logic [31:0] MAGIC_WORD = 32'h4D52_4644;

    localparam int ADDR_BITS = 4;
    localparam logic [1:0] REG_VERSION  = 2'd0;
    localparam logic [1:0] REG_MAX_VTX  = 2'd1;
    localparam logic [1:0] REG_MAX_IDX  = 2'd2;
    localparam logic [1:0] REG_LANDMARK = 2'd3;

    localparam logic [31:0] RST_VERSION  = 32'd1;
    localparam logic [16:0] RST_MAX_VTX  = 17'd100000;
    localparam logic [18:0] RST_MAX_IDX  = 19'd300000;
    localparam logic [15:0] RST_LANDMARK = 16'd468;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TOO_SMALL,
        ST_MAGIC,
        ST_VERSION,
        ST_COUNTS,
        ST_SIZE,
        ST_INDEX,
        ST_HANDLE
    } t_status;

    typedef enum logic [1:0] {
        KIND_VERTEX,
        KIND_INDEX,
        KIND_HANDLE
    } t_kind;

    typedef struct packed {
        logic [31:0] expected_version;
        logic [16:0] max_vertices;
        logic [18:0] max_indices;
        logic [15:0] landmark_count;
    } t_cfg;

    typedef struct packed {
        logic        elem_valid;
        t_kind       elem_kind;
        logic [31:0] elem_word;
        logic [15:0] handle_vertex;
        logic        done_res;
        t_status     status;
    } t_res;

endpackage

// File: rtl/mfsv_stream_if.sv
`timescale 1ns / 1ps

interface mfsv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface mfsv_res_if;
    logic        valid;
    logic        ready;
    logic        elem_valid;
    logic [1:0]  elem_kind;
    logic [31:0] elem_word;
    logic [15:0] handle_vertex;
    logic        done_res;
    logic [2:0]  status;

    modport source (
        output valid, output elem_valid, output elem_kind, output elem_word,
        output handle_vertex, output done_res, output status, input ready
    );
    modport sink (
        input valid, input elem_valid, input elem_kind, input elem_word,
        input handle_vertex, input done_res, input status, output ready
    );
endinterface

// File: rtl/mfsv_cfg.sv
`timescale 1ns / 1ps

module mfsv_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfsv_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output mfsv_pkg::t_cfg                 o_cfg
);

    mfsv_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version <= mfsv_pkg::RST_VERSION;
            r_cfg.max_vertices     <= mfsv_pkg::RST_MAX_VTX;
            r_cfg.max_indices      <= mfsv_pkg::RST_MAX_IDX;
            r_cfg.landmark_count   <= mfsv_pkg::RST_LANDMARK;
        end else if (wr_en) begin
            case (reg_sel)
                mfsv_pkg::REG_VERSION:  r_cfg.expected_version <= pwdata;
                mfsv_pkg::REG_MAX_VTX:  r_cfg.max_vertices     <= pwdata[16:0];
                mfsv_pkg::REG_MAX_IDX:  r_cfg.max_indices      <= pwdata[18:0];
                mfsv_pkg::REG_LANDMARK: r_cfg.landmark_count   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            mfsv_pkg::REG_VERSION:  prdata = r_cfg.expected_version;
            mfsv_pkg::REG_MAX_VTX:  prdata = {15'd0, r_cfg.max_vertices};
            mfsv_pkg::REG_MAX_IDX:  prdata = {13'd0, r_cfg.max_indices};
            mfsv_pkg::REG_LANDMARK: prdata = {16'd0, r_cfg.landmark_count};
            default:                prdata = '0;
        endcase
    end

endmodule

// File: rtl/mfsv_parse.sv
`timescale 1ns / 1ps

module mfsv_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mfsv_byte_if.sink            i_byte,
    input  mfsv_pkg::t_cfg       i_cfg,
    input  logic                 i_space,
    output logic                 o_push,
    output mfsv_pkg::t_res       o_res
);

    localparam int PB = mfsv_pkg::POS_BITS;
    localparam int NB = mfsv_pkg::NEED_BITS;
    localparam int LB = mfsv_pkg::LEN_BITS;

    // Header word number, taken from position bits [4:2].
    localparam logic [2:0] HW_MAGIC   = 3'd0;
    localparam logic [2:0] HW_VERSION = 3'd1;
    localparam logic [2:0] HW_VERTEX  = 3'd2;
    localparam logic [2:0] HW_INDEX   = 3'd3;

    function automatic logic mod3_zero(input logic [31:0] v);
        logic [6:0] s1;
        logic [4:0] s2;
        begin
            s1 = '0;
            for (int k = 0; k < 8; k++) begin
                s1 = s1 + 7'(v[4*k +: 4]);
            end
            s2 = 5'(s1[3:0]) + 5'(s1[6:4]);
            if (s2 >= 5'd12) s2 = s2 - 5'd12;
            if (s2 >= 5'd6)  s2 = s2 - 5'd6;
            if (s2 >= 5'd3)  s2 = s2 - 5'd3;
            mod3_zero = (s2 == 5'd0);
        end
    endfunction

    // input stage
    logic                r_in_valid;
    logic [7:0]          r_byte;
    logic                r_last;

    // file state
    logic [PB-1:0]       r_pos,  n_pos;
    logic [31:0]         r_word;
    logic [31:0]         r_vtot, n_vtot;
    logic [31:0]         r_itot, n_itot;
    logic                r_imod, n_imod;
    logic [NB-1:0]       r_vend, n_vend;
    logic [NB-1:0]       r_iend, n_iend;
    logic [NB-1:0]       r_hend, n_hend;
    logic [PB-1:0]       r_elen, n_elen;
    mfsv_pkg::t_status   r_hstat, n_hstat;
    mfsv_pkg::t_status   r_berr, n_berr;

    logic [31:0]         wg;
    logic                complete;
    logic                in_hdr;
    logic                body_step;
    logic                counts_bad;
    logic [NB-1:0]       iend_w;
    logic [NB-1:0]       hend_w;
    logic [LB-1:0]       hend_ext;
    logic [LB-1:0]       pos_ext;
    logic [PB:0]         pos_len;
    logic                size_bad;
    logic                produce;
    logic                advance;
    logic                accept;
    mfsv_pkg::t_status   u_hstat, u_berr;
    logic [PB-1:0]       u_elen;

    assign wg        = {r_byte, r_word[31:8]};
    assign complete  = (r_pos[1:0] == 2'b11);
    assign in_hdr    = (r_pos < mfsv_pkg::HDR_BYTES);
    assign body_step = !in_hdr && complete && (r_hstat == mfsv_pkg::ST_OK)
                       && (r_pos != mfsv_pkg::POS_MAX);
    assign pos_ext   = LB'(r_pos);
    assign pos_len   = {1'b0, r_pos} + 1'b1;

    assign counts_bad = (r_vtot == 32'd0) || (r_vtot > {15'd0, i_cfg.max_vertices})
                        || (r_itot > {13'd0, i_cfg.max_indices})
                        || (wg > {16'd0, i_cfg.landmark_count}) || !r_imod;
    assign iend_w   = r_vend + NB'({r_itot, 2'b00});
    assign hend_w   = iend_w + NB'({wg, 2'b00});
    assign hend_ext = LB'(hend_w);

    always_comb begin
        n_vtot  = r_vtot;
        n_itot  = r_itot;
        n_imod  = r_imod;
        n_vend  = r_vend;
        n_iend  = r_iend;
        n_hend  = r_hend;
        u_elen  = r_elen;
        u_hstat = r_hstat;
        u_berr  = r_berr;
        o_res   = '0;

        if (in_hdr && complete) begin
            case (r_pos[4:2])
                HW_MAGIC: begin
                    if (wg != mfsv_pkg::MAGIC_WORD) u_hstat = mfsv_pkg::ST_MAGIC;
                end
                HW_VERSION: begin
                    if (r_hstat == mfsv_pkg::ST_OK && wg != i_cfg.expected_version)
                        u_hstat = mfsv_pkg::ST_VERSION;
                end
                HW_VERTEX: begin
                    n_vtot = wg;
                end
                HW_INDEX: begin
                    n_itot = wg;
                    n_imod = mod3_zero(wg);
                    n_vend = NB'(mfsv_pkg::HDR_LEN) + NB'({r_vtot, 3'b000})
                             + NB'({r_vtot, 2'b00});
                end
                default: begin
                    if (r_hstat == mfsv_pkg::ST_OK) begin
                        if (counts_bad) begin
                            u_hstat = mfsv_pkg::ST_COUNTS;
                        end else begin
                            n_iend = iend_w;
                            n_hend = hend_w;
                            u_elen = (hend_ext >= LB'(mfsv_pkg::POS_MAX)) ?
                                     mfsv_pkg::POS_MAX : PB'(hend_ext);
                        end
                    end
                end
            endcase
        end

        if (body_step) begin
            if (pos_ext < LB'(r_vend)) begin
                o_res.elem_valid = 1'b1;
                o_res.elem_kind  = mfsv_pkg::KIND_VERTEX;
                o_res.elem_word  = wg;
            end else if (pos_ext < LB'(r_iend)) begin
                o_res.elem_valid = 1'b1;
                o_res.elem_kind  = mfsv_pkg::KIND_INDEX;
                o_res.elem_word  = wg;
                if (wg >= r_vtot && r_berr == mfsv_pkg::ST_OK)
                    u_berr = mfsv_pkg::ST_INDEX;
            end else if (pos_ext < LB'(r_hend)) begin
                o_res.elem_valid    = 1'b1;
                o_res.elem_kind     = mfsv_pkg::KIND_HANDLE;
                o_res.elem_word     = {16'd0, wg[15:0]};
                o_res.handle_vertex = wg[31:16];
                if ((wg[15:0] >= i_cfg.landmark_count || {16'd0, wg[31:16]} >= r_vtot)
                    && r_berr == mfsv_pkg::ST_OK)
                    u_berr = mfsv_pkg::ST_HANDLE;
            end
        end

        size_bad = (r_pos >= mfsv_pkg::POS_MAX - 1'b1) || (u_elen == mfsv_pkg::POS_MAX)
                   || (pos_len != {1'b0, u_elen});

        if (r_last) begin
            o_res.done_res = 1'b1;
            if (r_pos < mfsv_pkg::HDR_BYTES - 1'b1)
                o_res.status = mfsv_pkg::ST_TOO_SMALL;
            else if (u_hstat != mfsv_pkg::ST_OK)
                o_res.status = u_hstat;
            else if (size_bad)
                o_res.status = mfsv_pkg::ST_SIZE;
            else
                o_res.status = u_berr;
        end

        // advance the counter, then drop the file state after the last byte
        n_pos   = (r_pos == mfsv_pkg::POS_MAX) ? r_pos : r_pos + 1'b1;
        n_elen  = u_elen;
        n_hstat = u_hstat;
        n_berr  = u_berr;
        if (r_last) begin
            n_pos   = '0;
            n_hstat = mfsv_pkg::ST_OK;
            n_berr  = mfsv_pkg::ST_OK;
        end
    end

    assign produce      = o_res.elem_valid || r_last;
    assign advance      = r_in_valid && (!produce || i_space);
    assign o_push       = advance && produce;
    assign i_byte.ready = !r_in_valid || advance;
    assign accept       = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte.byte_value;
            r_last <= i_byte.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hstat <= mfsv_pkg::ST_OK;
            r_berr  <= mfsv_pkg::ST_OK;
        end else if (advance) begin
            r_pos   <= n_pos;
            r_hstat <= n_hstat;
            r_berr  <= n_berr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_word <= wg;
            r_vtot <= n_vtot;
            r_itot <= n_itot;
            r_imod <= n_imod;
            r_vend <= n_vend;
            r_iend <= n_iend;
            r_hend <= n_hend;
            r_elen <= n_elen;
        end
    end

endmodule

// File: rtl/mfsv_res_reg.sv
`timescale 1ns / 1ps

module mfsv_res_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mfsv_pkg::t_res i_res,
    output logic           o_space,
    mfsv_res_if.source     o_res
);

    logic           r_valid;
    mfsv_pkg::t_res r_res;

    assign o_space = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.elem_valid    = r_res.elem_valid;
    assign o_res.elem_kind     = r_res.elem_kind;
    assign o_res.elem_word     = r_res.elem_word;
    assign o_res.handle_vertex = r_res.handle_vertex;
    assign o_res.done_res      = r_res.done_res;
    assign o_res.status        = r_res.status;

endmodule

// File: rtl/mesh_file_stream_validator.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Word
// i_byte    in   valid/ready    byte_value, last_byte
// o_res     out  valid/ready    elem_valid, elem_kind, elem_word, handle_vertex,
//                               done_res, status
// APB       in   psel/penable   four config registers at byte addresses 0, 4, 8, 12
//
// One byte per cycle sustained while the output is not stalled. A byte sits in the input
// register while its header check, element decode and status are worked out, then the
// result word lands in the output register. Reset (i_rst_n low, synchronous) empties
// both stages, clears the byte position and file status and loads the register
// defaults. A stalled output holds its word while one more byte is taken into the
// input stage; bytes that make no word keep flowing past it.

module mesh_file_stream_validator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mfsv_byte_if.sink                      i_byte,
    mfsv_res_if.source                     o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfsv_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    mfsv_pkg::t_cfg w_cfg;
    mfsv_pkg::t_res w_res;
    logic           w_push;
    logic           w_space;

    // Register file: version, vertex limit, index limit, landmark limit.
    mfsv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input stage and file state: gather words, check the header, decode the body,
    // and pick the final status on the last byte.
    mfsv_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_cfg   (w_cfg),
        .i_space (w_space),
        .o_push  (w_push),
        .o_res   (w_res)
    );

    // Output register: hold the result word until the sink takes it.
    mfsv_res_reg u_res_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_space (w_space),
        .o_res   (o_res)
    );

endmodule
